@@ rtl/mbrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrc_pkg: shared types and constants for the Modbus RTU response checker
// Beat payload structs, CRC-16 constants and the byte-wise CRC update.
// ----------------------------------------------------------------------------
package mbrc_pkg;

  localparam int MAX_FRAME_DEF = 256;
  localparam int FRAME_LEN_W   = 9;
  localparam int REG_IDX_W     = 7;
  localparam int FIFO_DEPTH    = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_LSB  = 16'h0001;

  localparam logic KIND_REG    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_t;

  typedef struct packed {
    logic                   kind;
    logic [15:0]            reg_value;
    logic [REG_IDX_W-1:0]   reg_index;
    logic                   crc_ok;
    logic [7:0]             bit_byte;
    logic [FRAME_LEN_W-1:0] frame_len;
    logic                   last;
  } out_t;

  // results produced by one accepted byte, compacted into r0 then r1
  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
  } push_t;

  // reflected CRC-16 update over one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_LSB) != 16'h0000) c = (c >> 1) ^ CRC_POLY;
      else                           c = c >> 1;
    end
    return c;
  endfunction

endpackage

@@ rtl/modbus_rtu_response_checker.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker: Modbus RTU read response frame checker
// Checks the CRC-16 of a response and extracts its register values.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per beat, end_of_frame set on the last byte.
//   out_* : result beats. kind 0 is a register value (big-endian data pair,
//           reg_index counts pairs), kind 1 is the frame status (crc_ok,
//           bit_byte, frame_len) sent after the final byte. last marks the
//           final result caused by one input byte.
// Throughput: one byte per cycle while in_ready is high. A byte that closes a
//   data pair and also ends the frame yields two results, delivered on
//   consecutive beats; the four-entry result queue absorbs one such extra
//   result, and a second one before the queue drains can hold off the input.
// Latency: with an empty queue a result is valid the cycle after its byte
//   is accepted; the CRC update and pair logic sit between the frame state
//   and the queue.
// in_ready drops when the result queue has fewer than two free entries, so
//   a stalled receiver backs up the input once three results wait in the queue.
// Reset (synchronous, rst_n low) empties the queue and returns the frame
//   state to start-of-frame: CRC 0xFFFF, byte count zero.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker
  import mbrc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  push_t push;
  logic  space_ok;
  logic  in_fire;

  assign in_ready = space_ok;
  assign in_fire  = in_valid && in_ready;

  mbrc_frame #(
    .MAX_FRAME(MAX_FRAME)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .push    (push)
  );

  mbrc_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/mbrc_frame.sv @@
// ----------------------------------------------------------------------------
// mbrc_frame: per-byte frame tracking
// Delay line, running CRC, data pair assembly and end-of-frame status.
// ----------------------------------------------------------------------------
module mbrc_frame
  import mbrc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  in_t   in_data,
  output push_t push
);

  localparam int PW = $clog2(MAX_FRAME + 1);

  logic [15:0]          crc_r, crc_nxt, crc_upd;
  logic [PW-1:0]        pos_r, pos_nxt, pos_new, off;
  logic [7:0]           dly0_r, dly0_nxt, dly1_r, dly1_nxt;
  logic [7:0]           count_r, count_nxt;
  logic [7:0]           pair_r, pair_nxt;
  logic [7:0]           first_r, first_nxt;
  logic [REG_IDX_W-1:0] regs_r, regs_nxt;
  logic                 fresh, in_data_area, reg_v, eof;
  out_t                 reg_res, st_res;

  assign fresh        = pos_r < PW'(MAX_FRAME);
  assign off          = pos_r - PW'(5);
  assign in_data_area = fresh && (pos_r >= PW'(5)) && (16'(off) < 16'(count_r));
  assign eof          = in_data.end_of_frame;
  assign crc_upd      = (pos_r >= PW'(2)) ? crc_byte(crc_r, dly0_r) : crc_r;
  assign pos_new      = fresh ? pos_r + PW'(1) : pos_r;
  assign first_nxt    = (in_fire && eof) ? 8'h00 :
                        (in_fire && fresh && pos_r == PW'(3)) ? in_data.rx_byte : first_r;
  assign reg_v        = in_fire && in_data_area && off[0];

  always_comb begin
    reg_res           = '0;
    reg_res.kind      = KIND_REG;
    reg_res.reg_value = {pair_r, dly0_r};
    reg_res.reg_index = regs_r;
    reg_res.last      = !eof;

    st_res           = '0;
    st_res.kind      = KIND_STATUS;
    // received CRC: low byte is the previous byte held in dly1_r, high byte is this beat
    st_res.crc_ok    = (pos_new >= PW'(5)) && ({in_data.rx_byte, dly1_r} == crc_upd);
    st_res.bit_byte  = (pos_new >= PW'(4)) ?
                       ((fresh && pos_r == PW'(3)) ? in_data.rx_byte : first_r) : 8'h00;
    st_res.frame_len = FRAME_LEN_W'(pos_new);
    st_res.last      = 1'b1;
  end

  always_comb begin
    crc_nxt   = crc_r;
    pos_nxt   = pos_r;
    dly0_nxt  = dly0_r;
    dly1_nxt  = dly1_r;
    count_nxt = count_r;
    pair_nxt  = pair_r;
    regs_nxt  = regs_r;
    push      = '0;
    if (in_fire) begin
      crc_nxt  = crc_upd;
      pos_nxt  = pos_new;
      dly0_nxt = dly1_r;
      dly1_nxt = in_data.rx_byte;
      if (fresh && pos_r == PW'(2)) count_nxt = in_data.rx_byte;
      if (in_data_area && !off[0]) pair_nxt = dly0_r;
      if (reg_v) regs_nxt = regs_r + REG_IDX_W'(1);

      push.cnt = 2'(reg_v) + 2'(eof);
      push.r0  = reg_v ? reg_res : st_res;
      push.r1  = st_res;

      if (eof) begin
        crc_nxt   = CRC_INIT;
        pos_nxt   = '0;
        dly0_nxt  = '0;
        dly1_nxt  = '0;
        count_nxt = '0;
        pair_nxt  = '0;
        regs_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      pos_r   <= '0;
      dly0_r  <= '0;
      dly1_r  <= '0;
      count_r <= '0;
      pair_r  <= '0;
      first_r <= '0;
      regs_r  <= '0;
    end else begin
      crc_r   <= crc_nxt;
      pos_r   <= pos_nxt;
      dly0_r  <= dly0_nxt;
      dly1_r  <= dly1_nxt;
      count_r <= count_nxt;
      pair_r  <= pair_nxt;
      first_r <= first_nxt;
      regs_r  <= regs_nxt;
    end
  end

endmodule

@@ rtl/mbrc_out_fifo.sv @@
// ----------------------------------------------------------------------------
// mbrc_out_fifo: result queue
// Small register FIFO taking up to two results per cycle, one out per beat.
// ----------------------------------------------------------------------------
module mbrc_out_fifo
  import mbrc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  space_ok,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  out_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid  = cnt_r != '0;
  assign out_data   = mem_r[rd_ptr_r];
  assign pop        = out_valid && out_ready;
  // room for the worst case of two results from one beat
  assign space_ok   = cnt_r <= CNT_W'(FIFO_DEPTH - 2);
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign cnt_nxt    = cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_r + PTR_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ sim/mbrc_result_checker.sv @@
// ----------------------------------------------------------------------------
// mbrc_result_checker: result tracker for the Modbus RTU response checker
// Follows every accepted frame byte with its own CRC-16 and pair decoding,
// queues the results each byte should produce and compares out beats with them.
// ----------------------------------------------------------------------------
module mbrc_result_checker
  import mbrc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   results_due
);

  logic [15:0]          crc_run;
  int unsigned          rx_count;
  logic [7:0]           crc_line [2];
  logic [7:0]           claimed_count;
  logic [7:0]           pair_msb;
  logic [7:0]           coil_byte;
  logic [REG_IDX_W-1:0] pairs_sent;
  out_t                 due_results [$];

  function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic string fmt_result(input out_t r);
    return $sformatf("kind=%0d value=%04h index=%0d crc_ok=%0d bit_byte=%02h len=%0d last=%0d",
                     r.kind, r.reg_value, r.reg_index, r.crc_ok, r.bit_byte, r.frame_len,
                     r.last);
  endfunction

  task automatic clear_frame();
    crc_run       = CRC_INIT;
    rx_count      = 0;
    crc_line[0]   = 8'h00;
    crc_line[1]   = 8'h00;
    claimed_count = 8'h00;
    pair_msb      = 8'h00;
    coil_byte     = 8'h00;
    pairs_sent    = '0;
  endtask

  task automatic absorb_rx_byte(input in_t beat);
    logic        fresh;
    logic [7:0]  leaving;
    int unsigned q;
    int          made_cnt;
    out_t        made [2];
    fresh    = rx_count < MAX_FRAME;
    made_cnt = 0;
    made[0]  = '0;
    made[1]  = '0;
    if (fresh && rx_count == 2) claimed_count = beat.rx_byte;
    if (fresh && rx_count == 3) coil_byte = beat.rx_byte;
    // only bytes leaving the two-byte CRC line count as payload
    if (rx_count >= 2) begin
      leaving = crc_line[0];
      crc_run = crc16_modbus(crc_run, leaving);
      q = rx_count - 2;
      if (fresh && q >= 3 && (q - 3) < claimed_count) begin
        if (((q - 3) & 1) == 0) begin
          pair_msb = leaving;
        end else begin
          made[made_cnt].kind      = KIND_REG;
          made[made_cnt].reg_value = {pair_msb, leaving};
          made[made_cnt].reg_index = pairs_sent;
          made_cnt++;
          pairs_sent++;
        end
      end
    end
    crc_line[0] = crc_line[1];
    crc_line[1] = beat.rx_byte;
    if (fresh) rx_count++;
    if (beat.end_of_frame) begin
      made[made_cnt].kind      = KIND_STATUS;
      made[made_cnt].crc_ok    = (rx_count >= 5) && ({crc_line[1], crc_line[0]} == crc_run);
      made[made_cnt].bit_byte  = (rx_count >= 4) ? coil_byte : 8'h00;
      made[made_cnt].frame_len = FRAME_LEN_W'(rx_count);
      made_cnt++;
      clear_frame();
    end
    if (made_cnt > 0) made[made_cnt-1].last = 1'b1;
    for (int i = 0; i < made_cnt; i++) due_results.push_back(made[i]);
  endtask

  initial begin
    fail_count  = 0;
    results_due = 0;
    clear_frame();
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      clear_frame();
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result beat: %s", $realtime, fmt_result(out_data));
        end else begin
          want = due_results.pop_front();
          if (out_data.kind !== want.kind || out_data.reg_value !== want.reg_value ||
              out_data.reg_index !== want.reg_index || out_data.crc_ok !== want.crc_ok ||
              out_data.bit_byte !== want.bit_byte || out_data.frame_len !== want.frame_len ||
              out_data.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  want %s", fmt_result(want));
              $display("  got  %s", fmt_result(out_data));
            end
          end
        end
      end
      if (in_valid && in_ready) absorb_rx_byte(in_data);
    end
    results_due = due_results.size();
  end

endmodule

@@ sim/modbus_rtu_response_checker_test.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_test: testbench for the response checker
// Sends directed and random Modbus RTU response frames (well formed, corrupt,
// short, overlong, count beyond payload) with bursty input and a stalling
// result side; mbrc_result_checker tracks and compares every result beat.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_test
  import mbrc_pkg::*;
;

  localparam int TARGET_BYTES = 1350;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int fail_count;
  int results_due;
  int idle_cycles;
  int burst_left;
  int bytes_sent;
  logic hold_req;
  logic [7:0] frame_bytes [$];

  modbus_rtu_response_checker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mbrc_result_checker #(.MAX_FRAME(MAX_FRAME_DEF)) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no progress on either channel for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("modbus_rtu_response_checker verification failed");
      $finish;
    end
  end

  // result side: stall modes of random length, one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic logic [15:0] crc_of_frame();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_bytes[i]) begin
      c ^= {8'h00, frame_bytes[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic append_crc();
    logic [15:0] c;
    c = crc_of_frame();
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  task automatic append_random(input int n);
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_frame();
    int   gap;
    logic eof;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      eof = (i == frame_bytes.size() - 1);
      in_valid <= 1'b1;
      in_data  <= in_t'({frame_bytes[i], eof});
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
      burst_left--;
    end
    bytes_sent += frame_bytes.size();
    frame_bytes.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic build_random_frame(input int frame_no);
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (frame_no % 40 == 8) begin
      // overlong: may run past the frame size limit, count claims everything
      frame_bytes.push_back(8'h03);
      frame_bytes.push_back(8'hFF);
      append_random($urandom_range(245, 265));
      append_crc();
    end else if (pick < 55) begin
      case ($urandom_range(0, 9))
        0:       frame_bytes.push_back(8'($urandom_range(0, 255)));
        1, 2:    frame_bytes.push_back(8'h01);
        3:       frame_bytes.push_back(8'h02);
        4, 5, 6: frame_bytes.push_back(8'h03);
        default: frame_bytes.push_back(8'h04);
      endcase
      case ($urandom_range(0, 19))
        0:          n = $urandom_range(17, 40);
        1, 2, 3, 4: n = $urandom_range(0, 9);
        default:    n = 2 * $urandom_range(0, 8);
      endcase
      frame_bytes.push_back(8'(n));
      append_random(n);
      append_crc();
      if ($urandom_range(0, 7) == 0)
        frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] ^= 8'h01 << $urandom_range(0, 7);
    end else if (pick < 70) begin
      // count byte is random and mostly claims more data than the frame carries
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      append_random($urandom_range(0, 8));
      append_crc();
    end else if (pick < 85) begin
      append_random($urandom_range(0, 5));
    end else begin
      append_random($urandom_range(0, 19));
      if ($urandom_range(0, 1)) append_crc();
    end
  endtask

  initial begin
    int frame_no;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    hold_req   = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one-byte frame
    frame_bytes = {8'hFF};
    send_frame();
    // four bytes: coil byte present, still too short for a CRC check
    frame_bytes = {8'h00, 8'h01, 8'h02, 8'h80};
    send_frame();
    // shortest frame that can pass the CRC: empty data
    frame_bytes = {8'h01, 8'h01, 8'h00};
    append_crc();
    send_frame();
    // two registers at the value extremes
    frame_bytes = {8'hF7, 8'h03, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
    append_crc();
    send_frame();
    // odd count: trailing data byte is unpaired
    frame_bytes = {8'h11, 8'h03, 8'h01, 8'hA5};
    append_crc();
    send_frame();

    frame_no = 0;
    while (bytes_sent < TARGET_BYTES) begin
      if (frame_no == 3) hold_req = 1'b1;
      if (frame_no == 25 || frame_no == 60) wait_drained();
      build_random_frame(frame_no);
      send_frame();
      frame_no++;
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("modbus_rtu_response_checker verification clean");
    end else begin
      $display("modbus_rtu_response_checker verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mbrc_pkg.sv
rtl/mbrc_frame.sv
rtl/mbrc_out_fifo.sv
rtl/modbus_rtu_response_checker.sv
sim/mbrc_result_checker.sv
sim/modbus_rtu_response_checker_test.sv
